>>> design/rmth_pkg.sv
// Package for the running median block: default sizes, heap and operation codes,
// and the command struct passed from the item sequencer to the heap engine.
// No dependencies.
package rmth_pkg;

  localparam int MAX_ITEMS_DEF   = 1024;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam logic HEAP_LO = 1'b0;
  localparam logic HEAP_HI = 1'b1;

  localparam logic OP_PUSH    = 1'b0;
  localparam logic OP_REPLACE = 1'b1;

  typedef struct packed {
    logic start;
    logic kind;
    logic heap;
  } eng_cmd_t;

endpackage

>>> design/rmth_in_if.sv
// Input channel of the running median block: valid/ready and one signed sample per beat.
// Depends on nothing.
interface rmth_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

>>> design/rmth_out_if.sv
// Result channel of the running median block: valid/ready and one result per beat.
// Depends on nothing.
interface rmth_out_if #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 11
);
  logic                        valid;
  logic                        ready;
  logic signed [SAMPLE_BITS:0] median_twice;
  logic [COUNT_BITS-1:0]       stored_count;
  logic                        refused;

  modport source (output valid, output median_twice, output stored_count,
                  output refused, input ready);
  modport sink   (input valid, input median_twice, input stored_count,
                  input refused, output ready);
endinterface

>>> design/rmth_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module rmth_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/rmth_engine.sv
// Heap engine: sift-up for a push and sift-down for a top replacement, one level at a time,
// through a heap memory with registered read data. Depends on rmth_pkg.
module rmth_engine import rmth_pkg::*; #(
  parameter int SB  = SAMPLE_BITS_DEF,
  parameter int AW  = 9,
  parameter int SZW = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  eng_cmd_t             cmd,
  input  logic [SZW-1:0]       size,
  input  logic signed [SB-1:0] value,
  output logic                 busy,
  output logic                 done,
  output logic                 mem_we,
  output logic [AW-1:0]        mem_waddr,
  output logic [SB-1:0]        mem_wdata,
  output logic                 mem_re,
  output logic [AW-1:0]        mem_raddr,
  input  logic [SB-1:0]        mem_rdata
);

  localparam logic [2:0] E_IDLE   = 3'd0;
  localparam logic [2:0] E_UP_CHK = 3'd1;
  localparam logic [2:0] E_UP_CMP = 3'd2;
  localparam logic [2:0] E_DN_CHK = 3'd3;
  localparam logic [2:0] E_DN_RL  = 3'd4;
  localparam logic [2:0] E_DN_RR  = 3'd5;

  logic [2:0]           st_r, st_nxt;
  logic [AW-1:0]        pos_r, pos_nxt;
  logic signed [SB-1:0] val_r, val_nxt;
  logic [SZW-1:0]       size_r, size_nxt;
  logic                 max_r, max_nxt;
  logic signed [SB-1:0] lval_r, lval_nxt;

  logic [AW+1:0]        l_w, r_w, sz_w;
  logic [AW-1:0]        parent;
  logic signed [SB-1:0] rd;
  logic signed [SB-1:0] cval;
  logic [AW-1:0]        cidx;

  function automatic logic before_f(input logic signed [SB-1:0] a,
                                    input logic signed [SB-1:0] b, input logic is_max);
    before_f = is_max ? (a > b) : (a < b);
  endfunction

  assign rd     = mem_rdata;
  assign l_w    = {1'b0, pos_r, 1'b1};
  assign r_w    = l_w + {{(AW+1){1'b0}}, 1'b1};
  assign sz_w   = {{(AW+2-SZW){1'b0}}, size_r};
  assign parent = (pos_r - {{(AW-1){1'b0}}, 1'b1}) >> 1;
  assign busy   = (st_r != E_IDLE);

  always_comb begin
    st_nxt    = st_r;
    pos_nxt   = pos_r;
    val_nxt   = val_r;
    size_nxt  = size_r;
    max_nxt   = max_r;
    lval_nxt  = lval_r;
    done      = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = pos_r;
    mem_wdata = val_r;
    mem_re    = 1'b0;
    mem_raddr = parent;
    cval      = lval_r;
    cidx      = l_w[AW-1:0];
    case (st_r)
      E_IDLE: begin
        if (cmd.start) begin
          val_nxt  = value;
          size_nxt = size;
          max_nxt  = (cmd.heap == HEAP_LO);
          if (cmd.kind == OP_PUSH) begin
            pos_nxt = size[AW-1:0];
            st_nxt  = E_UP_CHK;
          end else begin
            pos_nxt = '0;
            st_nxt  = E_DN_CHK;
          end
        end
      end
      E_UP_CHK: begin
        if (pos_r == '0) begin
          mem_we = 1'b1;
          done   = 1'b1;
          st_nxt = E_IDLE;
        end else begin
          mem_re = 1'b1;
          st_nxt = E_UP_CMP;
        end
      end
      E_UP_CMP: begin
        mem_we = 1'b1;
        if (before_f(val_r, rd, max_r)) begin
          mem_wdata = rd;
          pos_nxt   = parent;
          st_nxt    = E_UP_CHK;
        end else begin
          done   = 1'b1;
          st_nxt = E_IDLE;
        end
      end
      E_DN_CHK: begin
        if (l_w >= sz_w) begin
          mem_we = 1'b1;
          done   = 1'b1;
          st_nxt = E_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = l_w[AW-1:0];
          st_nxt    = E_DN_RL;
        end
      end
      E_DN_RL: begin
        lval_nxt = rd;
        if (r_w < sz_w) begin
          mem_re    = 1'b1;
          mem_raddr = r_w[AW-1:0];
          st_nxt    = E_DN_RR;
        end else begin
          mem_we = 1'b1;
          if (before_f(rd, val_r, max_r)) begin
            mem_wdata = rd;
            pos_nxt   = l_w[AW-1:0];
            st_nxt    = E_DN_CHK;
          end else begin
            done   = 1'b1;
            st_nxt = E_IDLE;
          end
        end
      end
      E_DN_RR: begin
        if (before_f(rd, lval_r, max_r)) begin
          cval = rd;
          cidx = r_w[AW-1:0];
        end
        mem_we = 1'b1;
        if (before_f(cval, val_r, max_r)) begin
          mem_wdata = cval;
          pos_nxt   = cidx;
          st_nxt    = E_DN_CHK;
        end else begin
          done   = 1'b1;
          st_nxt = E_IDLE;
        end
      end
      default: begin
        st_nxt = E_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= E_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    pos_r  <= pos_nxt;
    val_r  <= val_nxt;
    size_r <= size_nxt;
    max_r  <= max_nxt;
    lval_r <= lval_nxt;
  end

endmodule

>>> design/running_median_two_heaps.sv
// Running median over two heaps held in two synchronous RAMs.
// A refused sample goes straight to its result beat. Otherwise the engine pushes a value into
// one heap, sifting it up level by level, and where the heaps would fall out of balance it also
// replaces the other heap's top and sifts it down before the result is registered. A new beat is
// taken only once the last result is registered; the engine and the result ready set the pace.
// Synchronous active-low reset empties both heaps; memory contents are not cleared.
module running_median_two_heaps import rmth_pkg::*; #(
  parameter int MAX_ITEMS   = MAX_ITEMS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  rmth_in_if.sink    in_bus,
  rmth_out_if.source out_bus
);

  localparam int HD  = (MAX_ITEMS + 1) / 2;
  localparam int AW  = $clog2(HD);
  localparam int SZW = $clog2(HD + 1);
  localparam int CW  = $clog2(MAX_ITEMS + 1);
  localparam int SB  = SAMPLE_BITS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_P1_GO = 3'd1;
  localparam logic [2:0] S_P1_WT = 3'd2;
  localparam logic [2:0] S_P2_GO = 3'd3;
  localparam logic [2:0] S_P2_WT = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]           st_r, st_nxt;
  logic [SZW-1:0]       lsize_r, lsize_nxt, usize_r, usize_nxt;
  logic signed [SB-1:0] ltop_r, utop_r;
  logic                 p1_heap_r, p1_heap_nxt, p2_heap_r, p2_heap_nxt, p2_en_r, p2_en_nxt;
  logic signed [SB-1:0] p1_val_r, p1_val_nxt, p2_val_r, p2_val_nxt;
  logic                 refused_r, refused_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [SB:0]   med_r, med_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 oref_r, oref_nxt;

  logic [CW-1:0]        total;
  logic signed [SB-1:0] x;
  logic                 cur_heap;
  eng_cmd_t             cmd;
  logic [SZW-1:0]       eng_size;
  logic signed [SB-1:0] eng_val;
  logic                 eng_busy, eng_done;
  logic                 m_we, m_re;
  logic [AW-1:0]        m_waddr, m_raddr;
  logic [SB-1:0]        m_wdata, lo_rdata, hi_rdata;
  logic                 lo_we, hi_we;

  assign total  = CW'(lsize_r) + CW'(usize_r);
  assign x      = in_bus.sample;
  assign in_bus.ready = (st_r == S_IDLE);

  assign cur_heap = (st_r == S_P2_GO || st_r == S_P2_WT) ? p2_heap_r : p1_heap_r;
  assign lo_we    = m_we && (cur_heap == HEAP_LO);
  assign hi_we    = m_we && (cur_heap == HEAP_HI);

  always_comb begin
    cmd.start = 1'b0;
    cmd.kind  = OP_PUSH;
    cmd.heap  = cur_heap;
    eng_val   = p1_val_r;
    if (st_r == S_P1_GO) begin
      cmd.start = 1'b1;
    end else if (st_r == S_P2_GO) begin
      cmd.start = 1'b1;
      cmd.kind  = OP_REPLACE;
      eng_val   = p2_val_r;
    end
    eng_size = (cur_heap == HEAP_LO) ? lsize_r : usize_r;
  end

  rmth_engine #(.SB(SB), .AW(AW), .SZW(SZW)) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .size      (eng_size),
    .value     (eng_val),
    .busy      (eng_busy),
    .done      (eng_done),
    .mem_we    (m_we),
    .mem_waddr (m_waddr),
    .mem_wdata (m_wdata),
    .mem_re    (m_re),
    .mem_raddr (m_raddr),
    .mem_rdata ((cur_heap == HEAP_LO) ? lo_rdata : hi_rdata)
  );

  rmth_ram #(.WIDTH(SB), .DEPTH(HD)) u_lower_ram (
    .clk   (clk),
    .we    (lo_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .re    (m_re && (cur_heap == HEAP_LO)),
    .raddr (m_raddr),
    .rdata (lo_rdata)
  );

  rmth_ram #(.WIDTH(SB), .DEPTH(HD)) u_upper_ram (
    .clk   (clk),
    .we    (hi_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .re    (m_re && (cur_heap == HEAP_HI)),
    .raddr (m_raddr),
    .rdata (hi_rdata)
  );

  always_comb begin
    st_nxt        = st_r;
    lsize_nxt     = lsize_r;
    usize_nxt     = usize_r;
    p1_heap_nxt   = p1_heap_r;
    p1_val_nxt    = p1_val_r;
    p2_heap_nxt   = p2_heap_r;
    p2_val_nxt    = p2_val_r;
    p2_en_nxt     = p2_en_r;
    refused_nxt   = refused_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;
    med_nxt       = med_r;
    cnt_nxt       = cnt_r;
    oref_nxt      = oref_r;
    case (st_r)
      S_IDLE: begin
        if (in_bus.valid) begin
          refused_nxt = 1'b0;
          p2_en_nxt   = 1'b0;
          p1_val_nxt  = x;
          st_nxt      = S_P1_GO;
          if (total >= CW'(MAX_ITEMS)) begin
            refused_nxt = 1'b1;
            st_nxt      = S_DONE;
          end else if (lsize_r == usize_r) begin
            p1_heap_nxt = (lsize_r == '0 || x < ltop_r) ? HEAP_LO : HEAP_HI;
          end else if (lsize_r < usize_r) begin
            p1_heap_nxt = HEAP_LO;
            if (x > utop_r) begin
              p1_val_nxt  = utop_r;
              p2_en_nxt   = 1'b1;
              p2_heap_nxt = HEAP_HI;
              p2_val_nxt  = x;
            end
          end else begin
            p1_heap_nxt = HEAP_HI;
            if (x < ltop_r) begin
              p1_val_nxt  = ltop_r;
              p2_en_nxt   = 1'b1;
              p2_heap_nxt = HEAP_LO;
              p2_val_nxt  = x;
            end
          end
        end
      end
      S_P1_GO: begin
        st_nxt = S_P1_WT;
      end
      S_P1_WT: begin
        if (eng_done) begin
          if (p1_heap_r == HEAP_LO) begin
            lsize_nxt = lsize_r + 1'b1;
          end else begin
            usize_nxt = usize_r + 1'b1;
          end
          st_nxt = p2_en_r ? S_P2_GO : S_DONE;
        end
      end
      S_P2_GO: begin
        st_nxt = S_P2_WT;
      end
      S_P2_WT: begin
        if (eng_done) begin
          st_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_bus.ready) begin
          out_valid_nxt = 1'b1;
          cnt_nxt       = total;
          oref_nxt      = refused_r;
          if (total == '0) begin
            med_nxt = '0;
          end else if (total[0]) begin
            med_nxt = (usize_r > lsize_r) ? {utop_r, 1'b0} : {ltop_r, 1'b0};
          end else begin
            med_nxt = (SB+1)'(ltop_r) + (SB+1)'(utop_r);
          end
          st_nxt = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      lsize_r     <= '0;
      usize_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      lsize_r     <= lsize_nxt;
      usize_r     <= usize_nxt;
      out_valid_r <= out_valid_nxt;
    end
    p1_heap_r <= p1_heap_nxt;
    p1_val_r  <= p1_val_nxt;
    p2_heap_r <= p2_heap_nxt;
    p2_val_r  <= p2_val_nxt;
    p2_en_r   <= p2_en_nxt;
    refused_r <= refused_nxt;
    med_r     <= med_nxt;
    cnt_r     <= cnt_nxt;
    oref_r    <= oref_nxt;
    if (lo_we && m_waddr == '0) begin
      ltop_r <= m_wdata;
    end
    if (hi_we && m_waddr == '0) begin
      utop_r <= m_wdata;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.median_twice = med_r;
  assign out_bus.stored_count = cnt_r;
  assign out_bus.refused      = oref_r;

  a_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (lsize_r == usize_r) || (lsize_r == usize_r + 1'b1) || (usize_r == lsize_r + 1'b1))
    else $error("heap sizes differ by more than one");

  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    total <= CW'(MAX_ITEMS))
    else $error("stored count above capacity");

  a_refuse_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && oref_r) |-> (cnt_r == CW'(MAX_ITEMS)))
    else $error("refused beat while store not full");

  a_engine_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE || st_r == S_DONE) |-> !eng_busy)
    else $error("heap engine busy outside an operation");

endmodule
